@@ design/sto2_pkg.sv @@
// Shared types, codes and constants for the two-wavelength StO2 estimator.
// Also holds the log10 table entry function that the front end builds its ROM from.
// No dependencies.
package sto2_pkg;

    localparam int FLOOR_RESET   = 200;
    localparam int CEILING_RESET = 1000;
    localparam int COEF_BITS     = 16;
    localparam int STO2_BITS     = 16;
    localparam int STO2_FRAC     = 14;
    localparam int QUOT_BITS     = 16;
    localparam int MUL_STEPS     = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam longint unsigned LOG10_2_Q28 = 64'd80807124;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FLOOR   = 3'd0,
        CFG_CEILING = 3'd1,
        CFG_A_HB    = 3'd2,
        CFG_A_HBO2  = 3'd3,
        CFG_B_HB    = 3'd4,
        CFG_B_HBO2  = 3'd5
    } cfg_index_t;

    typedef enum logic [0:0] {
        KIND_HELD = 1'b0,
        KIND_CALC = 1'b1
    } item_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_PREP,
        BK_CHECK,
        BK_DIV,
        BK_FIN
    } back_state_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] a_hb;
        logic signed [COEF_BITS-1:0] a_hbo2;
        logic signed [COEF_BITS-1:0] b_hb;
        logic signed [COEF_BITS-1:0] b_hbo2;
    } coef_set_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // round(log10(n) * 2^frac_bits) via Q.30 log2 by repeated squaring
    function automatic logic [31:0] log10_entry(input int unsigned n,
                                                input int unsigned frac_bits);
        longint unsigned y;
        longint unsigned frac;
        longint unsigned l2;
        longint unsigned p;
        int unsigned     e;
        frac = 0;
        e    = 0;
        if (n == 0)
            return 32'd0;
        while (e < 31 && (n >> (e + 1)) != 0)
            e++;
        y = longint'(n) << (30 - e);
        for (int i = 1; i <= 30; i++)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31))
            begin
                y = y >> 1;
                frac = frac | (64'd1 << (30 - i));
            end
        end
        l2 = (longint'(e) << 30) | frac;
        p  = l2 * LOG10_2_Q28;
        return 32'((p + (64'd1 << (57 - frac_bits))) >> (58 - frac_bits));
    endfunction

endpackage

@@ design/sto2_queue.sv @@
// Small register FIFO between the front end and the back end.
// Depends on sto2_pkg for the status struct.
module sto2_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [WIDTH-1:0]          push_data,
    input  logic                      pop,
    output logic [WIDTH-1:0]          pop_data,
    output sto2_pkg::fifo_status_t    status
);
    import sto2_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == CNT_BITS'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ design/sto2_front.sv @@
// Front end: takes items, conditions samples, looks up log10, forms OD deltas
// and classifies each item before queuing it. Depends on sto2_pkg.
module sto2_front #(
    parameter int SAMPLE_BITS   = 10,
    parameter int LOG_FRAC_BITS = 12,
    parameter int LOG_BITS      = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SAMPLE_BITS-1:0]      intensity_a,
    input  logic [SAMPLE_BITS-1:0]      intensity_b,
    input  logic [SAMPLE_BITS-1:0]      floor_level,
    input  logic [SAMPLE_BITS-1:0]      ceiling_level,
    output logic                        push,
    output logic [2*LOG_BITS+2:0]       push_data,
    input  sto2_pkg::fifo_status_t      status
);
    import sto2_pkg::*;

    localparam int ROM_DEPTH = 2 ** SAMPLE_BITS;
    localparam int DW        = LOG_BITS + 1;

    typedef logic [LOG_BITS-1:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int n = 0; n < ROM_DEPTH; n++)
            t[n] = LOG_BITS'(log10_entry(n, LOG_FRAC_BITS));
        return t;
    endfunction

    localparam rom_t LOG_ROM = build_rom();

    logic [SAMPLE_BITS-1:0] cond_a;
    logic [SAMPLE_BITS-1:0] cond_b;
    logic [LOG_BITS-1:0]    log_a_reg;
    logic [LOG_BITS-1:0]    log_b_reg;
    logic [LOG_BITS-1:0]    last_log_a_reg;
    logic [LOG_BITS-1:0]    last_log_b_reg;
    logic                   primed_reg;
    logic                   s1_valid_reg;
    logic                   accept;
    logic                   consume;
    logic signed [DW-1:0]   delta_a;
    logic signed [DW-1:0]   delta_b;
    item_kind_t             kind;

    function automatic logic [SAMPLE_BITS-1:0] condition(input logic [SAMPLE_BITS-1:0] v,
                                                         input logic [SAMPLE_BITS-1:0] lo,
                                                         input logic [SAMPLE_BITS-1:0] hi);
        logic [SAMPLE_BITS-1:0] c;
        c = (v < lo) ? SAMPLE_BITS'(1) : v;
        if (c > hi)
            c = hi;
        return c;
    endfunction

    assign cond_a = condition(intensity_a, floor_level, ceiling_level);
    assign cond_b = condition(intensity_b, floor_level, ceiling_level);

    assign consume  = s1_valid_reg && (!primed_reg || !status.full);
    assign in_ready = !s1_valid_reg || consume;
    assign accept   = in_valid && in_ready;

    assign delta_a  = DW'({1'b0, last_log_a_reg}) - DW'({1'b0, log_a_reg});
    assign delta_b  = DW'({1'b0, last_log_b_reg}) - DW'({1'b0, log_b_reg});
    assign kind     = (delta_a == '0 && delta_b == '0) ? KIND_HELD : KIND_CALC;
    assign push     = s1_valid_reg && primed_reg && !status.full;
    assign push_data = {kind, delta_a, delta_b};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            log_a_reg <= LOG_ROM[cond_a];
            log_b_reg <= LOG_ROM[cond_b];
        end
        if (consume)
        begin
            last_log_a_reg <= log_a_reg;
            last_log_b_reg <= log_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            primed_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (consume)
                s1_valid_reg <= 1'b0;
            if (consume)
                primed_reg <= 1'b1;
        end
    end

endmodule

@@ design/sto2_back.sv @@
// Back end: shared multiplier for adj(M)*delta, serial restoring divider,
// saturation and the output register. Depends on sto2_pkg.
module sto2_back #(
    parameter int LOG_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [2*LOG_BITS+2:0]                   pop_data,
    input  sto2_pkg::fifo_status_t                  status,
    output logic                                    pop,
    input  sto2_pkg::coef_set_t                     coefs,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [sto2_pkg::STO2_BITS-1:0]   sto2_value,
    output logic                                    held_flag,
    output logic                                    divide_fault
);
    import sto2_pkg::*;

    localparam int DW = LOG_BITS + 1;
    localparam int PW = DW + COEF_BITS;
    localparam int XW = PW + 1;
    localparam int SW = XW + 1;
    localparam int AW = XW - 1;
    localparam int NW = SW - 1;
    localparam int RW = NW + QUOT_BITS - 1;
    localparam int CW = SW + 1;

    back_state_t state_reg;
    back_state_t state_next;

    item_kind_t           q_kind;
    logic signed [DW-1:0] q_da;
    logic signed [DW-1:0] q_db;

    logic signed [DW-1:0]        da_reg;
    logic signed [DW-1:0]        db_reg;
    logic [2:0]                  step_reg;
    logic [3:0]                  bit_reg;
    logic signed [PW-1:0]        prod_reg;
    logic signed [XW-1:0]        x0_reg;
    logic signed [XW-1:0]        x1_reg;
    logic signed [SW-1:0]        sum_reg;
    logic [AW-1:0]               num_reg;
    logic [NW-1:0]               den_reg;
    logic                        neg_reg;
    logic                        sat_reg;
    logic                        fault_reg;
    logic [RW-1:0]               rem_reg;
    logic [RW-1:0]               dsh_reg;
    logic [QUOT_BITS-1:0]        quot_reg;
    logic signed [STO2_BITS-1:0] held_sto2_reg;

    logic                        out_valid_reg;
    logic signed [STO2_BITS-1:0] sto2_value_reg;
    logic                        held_flag_reg;
    logic                        divide_fault_reg;

    logic signed [COEF_BITS-1:0] mul_coef;
    logic signed [DW-1:0]        mul_delta;
    logic signed [PW-1:0]        prod_next;
    logic signed [XW-1:0]        prod_ext;
    logic                        out_free;
    logic                        load_held;
    logic                        load_calc;
    logic                        rem_ge;
    logic signed [STO2_BITS-1:0] calc_value;

    assign {q_kind, q_da, q_db} = pop_data;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_coef = coefs.b_hbo2; mul_delta = da_reg; end
            3'd1:    begin mul_coef = coefs.a_hbo2; mul_delta = db_reg; end
            3'd2:    begin mul_coef = coefs.a_hb;   mul_delta = db_reg; end
            default: begin mul_coef = coefs.b_hb;   mul_delta = da_reg; end
        endcase
    end

    assign prod_next = mul_coef * mul_delta;
    assign prod_ext  = {prod_reg[PW-1], prod_reg};
    assign rem_ge    = (rem_reg >= dsh_reg);

    always_comb
    begin
        if (fault_reg)
            calc_value = held_sto2_reg;
        else if (sat_reg)
            calc_value = neg_reg ? STO2_BITS'(-32768) : STO2_BITS'(32767);
        else if (neg_reg)
            calc_value = (quot_reg > QUOT_BITS'(32768)) ? STO2_BITS'(-32768)
                                                        : STO2_BITS'(-quot_reg);
        else
            calc_value = (quot_reg > QUOT_BITS'(32767)) ? STO2_BITS'(32767)
                                                        : STO2_BITS'(quot_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_held  = 1'b0;
        load_calc  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!status.empty)
                begin
                    if (q_kind == KIND_HELD)
                    begin
                        if (out_free)
                        begin
                            pop       = 1'b1;
                            load_held = 1'b1;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        state_next = BK_MUL;
                    end
                end
            end
            BK_MUL:
            begin
                if (step_reg == 3'(MUL_STEPS))
                    state_next = BK_SUM;
            end
            BK_SUM:   state_next = BK_PREP;
            BK_PREP:  state_next = BK_CHECK;
            BK_CHECK:
            begin
                if (den_reg == '0 || {2'b00, num_reg} >= CW'({den_reg, 2'b00}))
                    state_next = BK_FIN;
                else
                    state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (bit_reg == 4'(QUOT_BITS - 1))
                    state_next = BK_FIN;
            end
            BK_FIN:
            begin
                if (out_free)
                begin
                    load_calc  = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                da_reg   <= q_da;
                db_reg   <= q_db;
                step_reg <= '0;
            end
            BK_MUL:
            begin
                step_reg <= step_reg + 1'b1;
                prod_reg <= prod_next;
                case (step_reg)
                    3'd1:    x0_reg <= prod_ext;
                    3'd2:    x0_reg <= x0_reg - prod_ext;
                    3'd3:    x1_reg <= prod_ext;
                    3'd4:    x1_reg <= x1_reg - prod_ext;
                    default: ;
                endcase
            end
            BK_SUM:
                sum_reg <= {x0_reg[XW-1], x0_reg} + {x1_reg[XW-1], x1_reg};
            BK_PREP:
            begin
                neg_reg <= x1_reg[XW-1] ^ sum_reg[SW-1];
                num_reg <= x1_reg[XW-1] ? AW'(-x1_reg) : AW'(x1_reg);
                den_reg <= sum_reg[SW-1] ? NW'(-sum_reg) : NW'(sum_reg);
            end
            BK_CHECK:
            begin
                fault_reg <= (den_reg == '0);
                sat_reg   <= ({2'b00, num_reg} >= CW'({den_reg, 2'b00}));
                rem_reg   <= RW'({num_reg, {STO2_FRAC{1'b0}}});
                dsh_reg   <= RW'({den_reg, {(QUOT_BITS-1){1'b0}}});
                quot_reg  <= '0;
                bit_reg   <= '0;
            end
            BK_DIV:
            begin
                if (rem_ge)
                    rem_reg <= rem_reg - dsh_reg;
                quot_reg <= {quot_reg[QUOT_BITS-2:0], rem_ge};
                dsh_reg  <= dsh_reg >> 1;
                bit_reg  <= bit_reg + 1'b1;
            end
            default: ;
        endcase
        if (load_held)
            sto2_value_reg <= held_sto2_reg;
        else if (load_calc)
            sto2_value_reg <= calc_value;
        if (load_held || load_calc)
        begin
            held_flag_reg    <= load_held;
            divide_fault_reg <= load_calc && fault_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_sto2_reg <= '0;
        end
        else
        begin
            if (load_held || load_calc)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (load_calc && !fault_reg)
                held_sto2_reg <= calc_value;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sto2_value   = sto2_value_reg;
    assign held_flag    = held_flag_reg;
    assign divide_fault = divide_fault_reg;

endmodule

@@ design/two_wavelength_sto2_estimator.sv @@
// Top level of the two-wavelength StO2 estimator: configuration registers,
// front end, item queue and back end. Depends on sto2_pkg, sto2_front,
// sto2_queue and sto2_back.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    intensity_a, intensity_b
//  out      source     out_valid / out_ready  sto2_value, held_flag, divide_fault
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Front end takes one item a cycle while the queue has room; the back end sets
// throughput, one item at a time: a computed item takes pop, 5 multiply steps, sum,
// sign, range check, 16-step divider (skipped on saturation or a zero divisor) and
// result; a held item goes straight to the output register. The first item after reset
// gives no result. Reset is asynchronous and needs no clearing pass. A two-entry queue
// lets the front keep accepting while the back end or the output register stalls.
module two_wavelength_sto2_estimator #(
    parameter int SAMPLE_BITS   = 10,
    parameter int LOG_FRAC_BITS = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [SAMPLE_BITS-1:0]                  intensity_a,
    input  logic [SAMPLE_BITS-1:0]                  intensity_b,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [sto2_pkg::STO2_BITS-1:0]   sto2_value,
    output logic                                    held_flag,
    output logic                                    divide_fault,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [sto2_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [sto2_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import sto2_pkg::*;

    localparam int LOG_BITS = LOG_FRAC_BITS + $clog2(SAMPLE_BITS);
    localparam int QW       = 2 * LOG_BITS + 3;

    logic [SAMPLE_BITS-1:0] floor_reg;
    logic [SAMPLE_BITS-1:0] ceiling_reg;
    coef_set_t              coef_reg;

    logic                   push;
    logic [QW-1:0]          push_data;
    logic                   pop;
    logic [QW-1:0]          pop_data;
    fifo_status_t           status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg       <= SAMPLE_BITS'(FLOOR_RESET);
            ceiling_reg     <= SAMPLE_BITS'(CEILING_RESET);
            coef_reg.a_hb   <= COEF_BITS'(256);
            coef_reg.a_hbo2 <= '0;
            coef_reg.b_hb   <= '0;
            coef_reg.b_hbo2 <= COEF_BITS'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FLOOR:   floor_reg       <= cfg_data[SAMPLE_BITS-1:0];
                CFG_CEILING: ceiling_reg     <= cfg_data[SAMPLE_BITS-1:0];
                CFG_A_HB:    coef_reg.a_hb   <= cfg_data;
                CFG_A_HBO2:  coef_reg.a_hbo2 <= cfg_data;
                CFG_B_HB:    coef_reg.b_hb   <= cfg_data;
                CFG_B_HBO2:  coef_reg.b_hbo2 <= cfg_data;
                default:     ;
            endcase
        end
    end

    sto2_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS),
        .LOG_BITS      (LOG_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .intensity_a   (intensity_a),
        .intensity_b   (intensity_b),
        .floor_level   (floor_reg),
        .ceiling_level (ceiling_reg),
        .push          (push),
        .push_data     (push_data),
        .status        (status)
    );

    sto2_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (status)
    );

    sto2_back #(
        .LOG_BITS (LOG_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_data     (pop_data),
        .status       (status),
        .pop          (pop),
        .coefs        (coef_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sto2_value   (sto2_value),
        .held_flag    (held_flag),
        .divide_fault (divide_fault)
    );

endmodule

@@ bench/tb_two_wavelength_sto2_estimator.sv @@
// Self-checking testbench for two_wavelength_sto2_estimator: random handshakes on the
// in and out channels, a bit-exact StO2 predictor and a scoreboard of expected
// results. Depends on sto2_pkg and the estimator RTL.
module tb_two_wavelength_sto2_estimator;

    import sto2_pkg::*;

    localparam int SAMPLE_W    = 10;
    localparam int LOG_FRAC    = 12;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 64;

    typedef struct {
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        int                  gap;
    } sample_item_t;

    typedef struct {
        logic signed [STO2_BITS-1:0] value;
        logic                        held;
        logic                        fault;
    } sto2_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [SAMPLE_W-1:0]      intensity_a = '0;
    logic [SAMPLE_W-1:0]      intensity_b = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [STO2_BITS-1:0] sto2_value;
    logic                     held_flag;
    logic                     divide_fault;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    two_wavelength_sto2_estimator #(
        .SAMPLE_BITS   (SAMPLE_W),
        .LOG_FRAC_BITS (LOG_FRAC)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .intensity_a  (intensity_a),
        .intensity_b  (intensity_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sto2_value   (sto2_value),
        .held_flag    (held_flag),
        .divide_fault (divide_fault),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // predictor state and register shadow
    longint                       od_table [0:(1<<SAMPLE_W)-1];
    logic [SAMPLE_W-1:0]          floor_lvl = SAMPLE_W'(FLOOR_RESET);
    logic [SAMPLE_W-1:0]          ceil_lvl = SAMPLE_W'(CEILING_RESET);
    logic signed [COEF_BITS-1:0]  k_a_hb = 16'sd256;
    logic signed [COEF_BITS-1:0]  k_a_hbo2 = 16'sd0;
    logic signed [COEF_BITS-1:0]  k_b_hb = 16'sd0;
    logic signed [COEF_BITS-1:0]  k_b_hbo2 = 16'sd256;
    logic [SAMPLE_W-1:0]          prev_a = '0;
    logic [SAMPLE_W-1:0]          prev_b = '0;
    logic signed [STO2_BITS-1:0]  held_sto2 = '0;
    logic                         primed = 1'b0;

    sample_item_t pending_items [$];
    sto2_result_t expected_results [$];

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int   in_wait = 0;
    int   ready_wait = 0;
    int   gap_max = 5;
    int   cycle_count = 0;
    int   mismatches = 0;
    int   items_taken = 0;
    int   results_seen = 0;
    int   n_calc = 0;
    int   n_held = 0;
    int   n_fault = 0;
    int   n_settings = 0;

    logic [SAMPLE_W-1:0] gen_last_a = '0;
    logic [SAMPLE_W-1:0] gen_last_b = '0;
    logic [SAMPLE_W-1:0] gen_floor = SAMPLE_W'(FLOOR_RESET);
    logic [SAMPLE_W-1:0] gen_ceil = SAMPLE_W'(CEILING_RESET);

    // round(log10(n) * 2^LOG_FRAC), log2 built bit by bit from a squared mantissa
    function automatic longint od_log(input int unsigned n);
        longint unsigned mant;
        longint unsigned frac_bits;
        longint unsigned prod;
        int unsigned     msb;
        if (n == 0)
            return 0;
        msb = 0;
        frac_bits = 0;
        while ((n >> (msb + 1)) != 0)
            msb++;
        mant = 64'(n) << (30 - msb);
        for (int i = 1; i <= 30; i++)
        begin
            mant = (mant * mant) >> 30;
            if (mant >= 64'h8000_0000)
            begin
                mant = mant >> 1;
                frac_bits |= 64'd1 << (30 - i);
            end
        end
        prod = ((64'(msb) << 30) | frac_bits) * LOG10_2_Q28;
        return longint'((prod + (64'd1 << (57 - LOG_FRAC))) >> (58 - LOG_FRAC));
    endfunction

    function automatic logic [SAMPLE_W-1:0] condition_sample(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] c;
        c = v;
        if (c < floor_lvl)
            c = SAMPLE_W'(1);
        if (c > ceil_lvl)
            c = ceil_lvl;
        return c;
    endfunction

    task automatic apply_config(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
        case (cfg_index_t'(idx))
            CFG_FLOOR:   floor_lvl = data[SAMPLE_W-1:0];
            CFG_CEILING: ceil_lvl = data[SAMPLE_W-1:0];
            CFG_A_HB:    k_a_hb = data;
            CFG_A_HBO2:  k_a_hbo2 = data;
            CFG_B_HB:    k_b_hb = data;
            CFG_B_HBO2:  k_b_hbo2 = data;
            default: ;
        endcase
    endtask

    task automatic predict_sto2(input logic [SAMPLE_W-1:0] raw_a,
                                input logic [SAMPLE_W-1:0] raw_b);
        logic [SAMPLE_W-1:0] ca;
        logic [SAMPLE_W-1:0] cb;
        longint              da;
        longint              db;
        longint              x0;
        longint              x1;
        longint              s;
        longint              q;
        sto2_result_t        r;
        items_taken++;
        ca = condition_sample(raw_a);
        cb = condition_sample(raw_b);
        if (!primed)
        begin
            prev_a = ca;
            prev_b = cb;
            primed = 1'b1;
            return;
        end
        da = od_table[prev_a] - od_table[ca];
        db = od_table[prev_b] - od_table[cb];
        prev_a = ca;
        prev_b = cb;
        r.value = held_sto2;
        r.held = 1'b0;
        r.fault = 1'b0;
        if (da == 0 && db == 0)
        begin
            r.held = 1'b1;
            n_held++;
        end
        else
        begin
            x0 = longint'(k_b_hbo2) * da - longint'(k_a_hbo2) * db;
            x1 = longint'(k_a_hb) * db - longint'(k_b_hb) * da;
            s = x0 + x1;
            if (s == 0)
            begin
                r.fault = 1'b1;
                n_fault++;
            end
            else
            begin
                q = (x1 * 64'sd16384) / s;
                if (q > 32767)
                    q = 32767;
                else if (q < -32768)
                    q = -32768;
                r.value = STO2_BITS'(q);
                held_sto2 = r.value;
                n_calc++;
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic check_sto2();
        sto2_result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: sto2 %0d held %0b fault %0b",
                         sto2_value, held_flag, divide_fault);
        end
        else
        begin
            want = expected_results.pop_front();
            if (sto2_value !== want.value || held_flag !== want.held
                || divide_fault !== want.fault)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: expected sto2 %0d held %0b fault %0b, ",
                              "got %0d %0b %0b"},
                             results_seen, want.value, want.held, want.fault,
                             sto2_value, held_flag, divide_fault);
            end
        end
    endtask

    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        out_fire <= out_valid && out_ready;
        if (rst_n)
        begin
            cycle_count++;
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (in_valid && in_ready)
                predict_sto2(intensity_a, intensity_b);
            if (out_valid && out_ready)
                check_sto2();
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        logic         next_valid;
        sample_item_t cur;
        next_valid = in_valid && !in_fire;
        if (rst_n && !next_valid && pending_items.size() != 0)
        begin
            if (in_wait < pending_items[0].gap)
                in_wait++;
            else
            begin
                cur = pending_items.pop_front();
                intensity_a <= cur.a;
                intensity_b <= cur.b;
                next_valid = 1'b1;
                in_wait = 0;
            end
        end
        in_valid <= next_valid;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                ready_wait = $urandom_range(0, gap_max);
            else if (ready_wait > 0)
                ready_wait--;
            out_ready <= (ready_wait == 0);
        end
    end

    task automatic push_item(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
        sample_item_t it;
        it.a = a;
        it.b = b;
        it.gap = $urandom_range(0, gap_max);
        pending_items.push_back(it);
        gen_last_a = a;
        gen_last_b = b;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_boundary();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return SAMPLE_W'(1);
            2: return '1;
            3: return SAMPLE_W'(gen_floor - SAMPLE_W'(1));
            4: return gen_floor;
            5: return gen_ceil;
            default: return SAMPLE_W'(gen_ceil + SAMPLE_W'(1));
        endcase
    endfunction

    // repeats give held results, swaps of the two channels give opposite OD changes
    task automatic add_random_items(input int count, input int swap_pct);
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
                push_item(gen_last_a, gen_last_b);
            else if (kind < 15 + swap_pct)
                push_item(gen_last_b, gen_last_a);
            else if (kind < 30 + swap_pct)
                push_item(pick_boundary(), pick_boundary());
            else
                push_item(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // upper bits of the level writes carry junk that the block must drop
    task automatic set_config(input logic [SAMPLE_W-1:0] fl, input logic [SAMPLE_W-1:0] cl,
                              input logic [15:0] a_hb, input logic [15:0] a_hbo2,
                              input logic [15:0] b_hb, input logic [15:0] b_hbo2);
        write_reg(CFG_FLOOR, {6'($urandom), fl});
        write_reg(CFG_CEILING, {6'($urandom), cl});
        write_reg(CFG_A_HB, a_hb);
        write_reg(CFG_A_HBO2, a_hbo2);
        write_reg(CFG_B_HB, b_hb);
        write_reg(CFG_B_HBO2, b_hbo2);
        @(negedge clk);
        cfg_valid <= 1'b0;
        gen_floor = fl;
        gen_ceil = cl;
        n_settings++;
    endtask

    initial
    begin
        logic [15:0] sym_c;
        logic [15:0] sym_d;
        for (int n = 0; n < (1 << SAMPLE_W); n++)
            od_table[n] = od_log(n);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_item(10'd500, 10'd500);
        push_item(10'd500, 10'd500);
        push_item(10'd0, 10'd1023);
        push_item(10'd199, 10'd1001);
        push_item(10'd200, 10'd1000);
        push_item(10'd1, 10'd0);
        push_item(10'd400, 10'd800);
        push_item(10'd800, 10'd400);
        push_item(10'd800, 10'd400);
        push_item(10'd1023, 10'd1023);
        push_item(10'd0, 10'd0);
        push_item(10'd512, 10'd256);
        push_item(10'd300, 10'd900);
        push_item(10'd900, 10'd300);
        push_item(10'd999, 10'd201);
        push_item(10'd201, 10'd999);
        push_item(10'h2AA, 10'h155);
        push_item(10'h155, 10'h2AA);
        settle();

        set_config(10'd0, 10'd1023, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        push_item(10'd0, 10'd1023);
        push_item(10'd1023, 10'd0);
        add_random_items(60, 5);
        settle();

        set_config(10'd1023, 10'd0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        add_random_items(15, 0);
        settle();

        set_config(10'd600, 10'd300, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        add_random_items(40, 5);
        settle();

        set_config(10'd100, 10'd900, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        add_random_items(50, 10);
        settle();

        set_config(10'd50, 10'd1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_random_items(25, 0);
        settle();

        gap_max = 0;
        sym_c = 16'($urandom);
        sym_d = 16'($urandom);
        set_config(10'($urandom_range(0, 300)), 10'($urandom_range(700, 1023)),
                   sym_c, sym_d, sym_d, sym_c);
        add_random_items(60, 30);
        settle();
        gap_max = 5;

        for (int p = 0; p < 4; p++)
        begin
            set_config(10'($urandom_range(0, 300)), 10'($urandom_range(700, 1023)),
                       16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            add_random_items(50, 5);
            settle();
        end

        $display({"Ran %0d samples across %0d register settings: ",
                  "%0d computed, %0d held, %0d divide faults."},
                 items_taken, n_settings, n_calc, n_held, n_fault);
        $display("%0d results checked, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
